// ===== rtl/uer_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types, register codes and arithmetic constants of the ultrasonic
// echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  // field widths
  localparam int unsigned TICK_W = 16;
  localparam int unsigned DIST_W = 6;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 2;

  // default timer ticks per microsecond
  localparam int unsigned TICKS_PER_US_DEF = 3;

  // register reset values
  localparam logic [TICK_W-1:0] TRIGGER_TICKS_RST   = 16'd30;
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST   = 16'd12288;
  localparam logic [DIST_W-1:0] CLAMP_MAX_RST       = 6'd30;
  localparam logic [DIST_W-1:0] SATURATED_VALUE_RST = 6'd15;

  // distance = us * SOUND_NUM / SOUND_DEN, done as one reciprocal multiply
  localparam longint unsigned SOUND_NUM  = 17;
  localparam longint unsigned SOUND_DEN  = 1000;
  localparam int unsigned     DIV_SHIFT  = 31;
  localparam longint unsigned RECIP_DEN  =
    ((64'd1 << DIV_SHIFT) + SOUND_DEN - 1) / SOUND_DEN;
  localparam int unsigned     DMULT_W    = 26;
  localparam logic [DMULT_W-1:0] DIST_MULT = DMULT_W'(SOUND_NUM * RECIP_DEN);
  // raw distance before clamp: at most 65535 * 17 / 1000
  localparam int unsigned     RAW_W      = 11;

  // microseconds = ticks / ticks_per_us, as a reciprocal multiply
  localparam int unsigned US_SHIFT = 32;
  localparam int unsigned UMULT_W  = US_SHIFT + 1;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_TRIGGER_TICKS   = 2'd0,
    CFG_TIMEOUT_TICKS   = 2'd1,
    CFG_CLAMP_MAX       = 2'd2,
    CFG_SATURATED_VALUE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TICK_W-1:0] trigger_ticks;
    logic [TICK_W-1:0] timeout_ticks;
    logic [DIST_W-1:0] clamp_max;
    logic [DIST_W-1:0] saturated_value;
  } cfg_t;

  // per-tick flags that travel with the word down the pipeline
  typedef struct packed {
    logic trigger;
    logic busy;
    logic done;
    logic timed_out;
    logic fall;
  } flags_t;

  // state step result: flags plus the echo width on a fall
  typedef struct packed {
    flags_t            flags;
    logic [TICK_W-1:0] ticks;
  } meas_t;

  typedef struct packed {
    logic              trigger;
    logic              busy;
    logic              done;
    logic              timed_out;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage : uer_pkg
`default_nettype wire

// ===== rtl/uer_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_fsm
// Measurement sequencer: trigger pulse, wait for echo rise, echo width count.
// One tick is stepped per accepted word; the tick result is registered.
// ----------------------------------------------------------------------------
module uer_fsm (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step_valid,
  output logic               step_ready,
  input  wire logic          start_req,
  input  wire logic          echo,
  input  wire uer_pkg::cfg_t cfg,
  output logic               meas_valid,
  input  wire logic          meas_ready,
  output uer_pkg::meas_t     meas
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_RISE = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_t;

  phase_t                     phase, phase_next;
  logic [uer_pkg::TICK_W-1:0] tick_count, tick_next;
  logic [uer_pkg::TICK_W-1:0] tick_inc;
  logic [uer_pkg::TICK_W-1:0] tlen, tlim;
  uer_pkg::meas_t             meas_next;
  logic                       step;

  assign step_ready = !meas_valid || meas_ready;
  assign step       = step_valid && step_ready;

  // zero limits act as one
  assign tlen     = (cfg.trigger_ticks == '0) ? uer_pkg::TICK_W'(1) : cfg.trigger_ticks;
  assign tlim     = (cfg.timeout_ticks == '0) ? uer_pkg::TICK_W'(1) : cfg.timeout_ticks;
  assign tick_inc = tick_count + uer_pkg::TICK_W'(1);

  // next state and tick result
  always_comb begin
    phase_next = phase;
    tick_next  = tick_count;
    meas_next  = '0;
    unique case (phase)
      PH_IDLE: begin
        if (start_req) begin
          meas_next.flags.trigger = 1'b1;
          if (uer_pkg::TICK_W'(1) >= tlen) begin
            phase_next = PH_RISE;
            tick_next  = '0;
          end else begin
            phase_next = PH_TRIG;
            tick_next  = uer_pkg::TICK_W'(1);
          end
        end
      end
      PH_TRIG: begin
        meas_next.flags.trigger = 1'b1;
        if (tick_inc >= tlen) begin
          phase_next = PH_RISE;
          tick_next  = '0;
        end else begin
          tick_next = tick_inc;
        end
      end
      PH_RISE: begin
        if (echo) begin
          phase_next = PH_MEAS;
          tick_next  = '0;
        end else if (tick_inc >= tlim) begin
          meas_next.flags.done      = 1'b1;
          meas_next.flags.timed_out = 1'b1;
          phase_next = PH_IDLE;
          tick_next  = '0;
        end else begin
          tick_next = tick_inc;
        end
      end
      PH_MEAS: begin
        if (!echo) begin
          meas_next.flags.done = 1'b1;
          meas_next.flags.fall = 1'b1;
          meas_next.ticks      = tick_count;
          phase_next = PH_IDLE;
          tick_next  = '0;
        end else if (tick_inc >= tlim) begin
          meas_next.flags.done      = 1'b1;
          meas_next.flags.timed_out = 1'b1;
          phase_next = PH_IDLE;
          tick_next  = '0;
        end else begin
          tick_next = tick_inc;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        tick_next  = '0;
      end
    endcase
    meas_next.flags.busy = (phase_next != PH_IDLE);
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_next;
    end
  end

  // tick result register
  always_ff @(posedge clk) begin
    if (rst) begin
      meas_valid <= 1'b0;
    end else if (step_ready) begin
      meas_valid <= step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      meas <= meas_next;
    end
  end

endmodule : uer_fsm
`default_nettype wire

// ===== rtl/uer_dist.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_dist
// Echo width to distance: ticks to microseconds, microseconds to centimetres,
// then clamp. Three registered stages, each advancing on its own handshake.
// ----------------------------------------------------------------------------
module uer_dist #(
  parameter int unsigned TICKS_PER_US = uer_pkg::TICKS_PER_US_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       meas_valid,
  output logic                            meas_ready,
  input  wire uer_pkg::meas_t             meas,
  input  wire logic [uer_pkg::DIST_W-1:0] clamp_max,
  input  wire logic [uer_pkg::DIST_W-1:0] saturated_value,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output uer_pkg::res_t                   res
);

  localparam int unsigned UPROD_W = uer_pkg::TICK_W + uer_pkg::UMULT_W;
  localparam int unsigned DPROD_W = uer_pkg::TICK_W + uer_pkg::DMULT_W;
  // ceiling reciprocal, exact for 16-bit ticks and divisors up to 16
  localparam logic [uer_pkg::UMULT_W-1:0] US_MULT = uer_pkg::UMULT_W'(
    ((64'd1 << uer_pkg::US_SHIFT) + 64'(TICKS_PER_US) - 64'd1) / 64'(TICKS_PER_US));

  logic                        us_valid, raw_valid;
  logic                        us_ready, raw_ready, out_ready_int;
  uer_pkg::flags_t             us_flags, raw_flags;
  logic [uer_pkg::TICK_W-1:0]  us;
  logic [uer_pkg::RAW_W-1:0]   raw;
  logic [UPROD_W-1:0]          us_prod;
  logic [DPROD_W-1:0]          raw_prod;
  logic [uer_pkg::DIST_W-1:0]  clamped, dist_cm;

  // ready chain, a stage takes a word when empty or draining
  assign out_ready_int = !res_valid || res_ready;
  assign raw_ready     = !raw_valid || out_ready_int;
  assign us_ready      = !us_valid  || raw_ready;
  assign meas_ready    = us_ready;

  // ticks to microseconds
  assign us_prod = UPROD_W'(meas.ticks) * UPROD_W'(US_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      us_valid <= 1'b0;
    end else if (us_ready) begin
      us_valid <= meas_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (meas_valid && us_ready) begin
      us_flags <= meas.flags;
      us       <= us_prod[uer_pkg::US_SHIFT +: uer_pkg::TICK_W];
    end
  end

  // microseconds to centimetres
  assign raw_prod = DPROD_W'(us) * DPROD_W'(uer_pkg::DIST_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
    end else if (raw_ready) begin
      raw_valid <= us_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (us_valid && raw_ready) begin
      raw_flags <= us_flags;
      raw       <= raw_prod[uer_pkg::DIV_SHIFT +: uer_pkg::RAW_W];
    end
  end

  // clamp, and the clamp value itself reports as saturated; distance is zero without a fall
  always_comb begin
    clamped = (raw > uer_pkg::RAW_W'(clamp_max)) ? clamp_max : raw[uer_pkg::DIST_W-1:0];
    dist_cm = (clamped == clamp_max) ? saturated_value : clamped;
    if (!raw_flags.fall) begin
      dist_cm = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready_int) begin
      res_valid <= raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_valid && out_ready_int) begin
      res.trigger   <= raw_flags.trigger;
      res.busy      <= raw_flags.busy;
      res.done      <= raw_flags.done;
      res.timed_out <= raw_flags.timed_out;
      res.distance  <= dist_cm;
    end
  end

endmodule : uer_dist
`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// One-sensor ultrasonic ranger stepped once per timer tick word.
// ----------------------------------------------------------------------------
// Each input word is one timer tick carrying the sampled echo level and a
// start request; each produces exactly one result word with the trigger
// level, busy, done, timeout and distance in centimetres. The unit takes one
// word per clock cycle while out_ready does not stall it; each word taken
// into the input register passes the sequencer step register, two reciprocal
// multiplier stages, then the clamp into the output register. The rate is set
// by the sequencer's phase and tick counter, which update once per accepted word.
// Registers are written through cfg_we, cfg_index and cfg_data and should be
// changed only while no word is in flight.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit #(
  parameter int unsigned TICKS_PER_US = uer_pkg::TICKS_PER_US_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       start_req,
  input  wire logic                       echo,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            trigger,
  output logic                            busy_res,
  output logic                            done_res,
  output logic                            timed_out,
  output logic [uer_pkg::DIST_W-1:0]      distance_cm,
  input  wire logic                       cfg_we,
  input  wire logic [uer_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [uer_pkg::CFG_W-1:0]  cfg_data
);

  uer_pkg::cfg_t  cfg;
  logic           s0_valid, s0_ready;
  logic           s0_start, s0_echo;
  logic           meas_valid, meas_ready;
  uer_pkg::meas_t meas;
  uer_pkg::res_t  res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks   <= uer_pkg::TRIGGER_TICKS_RST;
      cfg.timeout_ticks   <= uer_pkg::TIMEOUT_TICKS_RST;
      cfg.clamp_max       <= uer_pkg::CLAMP_MAX_RST;
      cfg.saturated_value <= uer_pkg::SATURATED_VALUE_RST;
    end else if (cfg_we) begin
      unique case (uer_pkg::cfg_idx_t'(cfg_index))
        uer_pkg::CFG_TRIGGER_TICKS:   cfg.trigger_ticks   <= cfg_data;
        uer_pkg::CFG_TIMEOUT_TICKS:   cfg.timeout_ticks   <= cfg_data;
        uer_pkg::CFG_CLAMP_MAX:       cfg.clamp_max       <= cfg_data[uer_pkg::DIST_W-1:0];
        uer_pkg::CFG_SATURATED_VALUE: cfg.saturated_value <= cfg_data[uer_pkg::DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  assign in_ready = !s0_valid || s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_start <= start_req;
      s0_echo  <= echo;
    end
  end

  // measurement sequencer
  uer_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step_valid (s0_valid),
    .step_ready (s0_ready),
    .start_req  (s0_start),
    .echo       (s0_echo),
    .cfg        (cfg),
    .meas_valid (meas_valid),
    .meas_ready (meas_ready),
    .meas       (meas)
  );

  // distance pipeline and output register
  uer_dist #(
    .TICKS_PER_US (TICKS_PER_US)
  ) u_dist (
    .clk             (clk),
    .rst             (rst),
    .meas_valid      (meas_valid),
    .meas_ready      (meas_ready),
    .meas            (meas),
    .clamp_max       (cfg.clamp_max),
    .saturated_value (cfg.saturated_value),
    .res_valid       (out_valid),
    .res_ready       (out_ready),
    .res             (res)
  );

  assign trigger     = res.trigger;
  assign busy_res    = res.busy;
  assign done_res    = res.done;
  assign timed_out   = res.timed_out;
  assign distance_cm = res.distance;

  // a finished measurement leaves the unit idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done word still reports busy");

  // timeout and distance only come with done
  a_flags_need_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> !timed_out && (distance_cm == '0))
    else $error("timeout or distance without done");

  // the trigger is driven only while a measurement runs
  a_trigger_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger |-> busy_res && !done_res)
    else $error("trigger outside a running measurement");

endmodule : ultrasonic_echo_ranger_unit
`default_nettype wire
